// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port checks module. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Check cons in the cycle after ante holds
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== design/cfn_pkg.sv =====
// ---------------------------------------------------------------------------
// cfn_pkg
// Shared types and constants of the cascaded FIR notch filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfn_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int FRAC_BITS  = 15;
    localparam int COEF_IDX_W = 6;
    localparam int IDX_EXT_W  = 9;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // Request kinds on the input channel
    typedef enum logic [0:0] {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } op_t;

    // Filter stage / coefficient table select
    typedef enum logic [0:0] {
        STAGE_FIRST  = 1'b0,
        STAGE_SECOND = 1'b1
    } stage_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_LOAD  = 3'd1,
        S_MAC   = 3'd2,
        S_DRAIN = 3'd3,
        S_SCALE = 3'd4,
        S_DONE  = 3'd5
    } seq_state_t;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic issue;
        logic live;
    } mac_ctrl_t;

    // Multiply-accumulate unit back to the sequencer
    typedef struct packed {
        logic busy;
    } mac_stat_t;

endpackage

`default_nettype wire

// ===== design/cfn_ram.sv =====
// ---------------------------------------------------------------------------
// cfn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfn_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write one entry, register one read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/cfn_mac.sv =====
// ---------------------------------------------------------------------------
// cfn_mac
// Shared multiply-accumulate unit: read-align, multiply, accumulate stages,
// plus the Q15 scale and 16-bit saturation of the finished sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfn_mac
    import cfn_pkg::*;
#(
    parameter int ACC_W = 39
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mac_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0] coef,
    input  wire logic signed [SAMPLE_W-1:0] data,
    output mac_stat_t                       stat,
    output logic signed [SAMPLE_W-1:0]      result
);

    logic                     rd_v_reg;
    logic                     live_reg;
    logic                     prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [ACC_W-31:0]        acc_hi;
    logic                     in_range;

    // Track which cycles carry valid read data and products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            live_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= ctrl.issue;
            live_reg   <= ctrl.live;
            prod_v_reg <= rd_v_reg;
        end
    end

    // Multiply; drop taps whose delay entry has not been filled yet
    always_ff @(posedge clk)
    begin
        if (live_reg)
        begin
            prod_reg <= coef * data;
        end
        else
        begin
            prod_reg <= '0;
        end
    end

    // Accumulate at full precision
    always_comb
    begin
        acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Floor-shift by 15 and saturate: bits above the result must match its sign
    always_comb
    begin
        acc_hi   = acc_reg[ACC_W-1:FRAC_BITS+SAMPLE_W-1];
        in_range = (&acc_hi) || (~|acc_hi);
        if (in_range)
        begin
            result = acc_reg[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        end
        else if (acc_reg[ACC_W-1])
        begin
            result = SAT_MIN;
        end
        else
        begin
            result = SAT_MAX;
        end
    end

    assign stat.busy = rd_v_reg | prod_v_reg;

endmodule

`default_nettype wire

// ===== design/cfn_seq.sv =====
// ---------------------------------------------------------------------------
// cfn_seq
// Sequencer: walks both filter stages through the shared MAC and keeps the
// circular delay-line pointers and fill count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfn_seq
    import cfn_pkg::*;
#(
    parameter int TAPS = 64,
    parameter int AW   = 6,
    parameter int CW   = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       out_free,
    input  wire mac_stat_t                  mac_stat,
    input  wire logic signed [SAMPLE_W-1:0] sat_value,
    output mac_ctrl_t                       mac_ctrl,
    output logic                            busy,
    output stage_t                          stage,
    output logic                            line_we,
    output logic [AW-1:0]                   line_waddr,
    output logic [AW-1:0]                   line_raddr,
    output logic [AW-1:0]                   coef_raddr,
    output logic signed [SAMPLE_W-1:0]      y1,
    output logic signed [SAMPLE_W-1:0]      y2,
    output logic                            load_out
);

    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);
    localparam logic [CW-1:0] FULL     = CW'(TAPS);

    seq_state_t                 state_reg;
    seq_state_t                 state_next;
    stage_t                     stage_reg;
    logic [AW-1:0]              tap_reg;
    logic [AW-1:0]              rd_ptr_reg;
    logic [AW-1:0]              wptr_reg;
    logic [CW-1:0]              fill_reg;
    logic signed [SAMPLE_W-1:0] y1_reg;
    logic signed [SAMPLE_W-1:0] y2_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (tap_reg == LAST_TAP)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_stat.busy)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (stage_reg == STAGE_FIRST)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs decoded from state
    always_comb
    begin
        busy           = 1'b1;
        line_we        = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.issue = 1'b0;
        mac_ctrl.live  = (CW'(tap_reg) <= fill_reg);
        load_out       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_LOAD:
            begin
                line_we        = 1'b1;
                mac_ctrl.clear = 1'b1;
            end
            S_MAC:
            begin
                mac_ctrl.issue = 1'b1;
            end
            S_DRAIN, S_SCALE:
            begin
            end
            S_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Stage, tap counter, pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= STAGE_FIRST;
            tap_reg    <= '0;
            rd_ptr_reg <= '0;
            wptr_reg   <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    stage_reg <= STAGE_FIRST;
                end
                S_LOAD:
                begin
                    tap_reg    <= '0;
                    rd_ptr_reg <= wptr_reg;
                end
                S_MAC:
                begin
                    tap_reg <= tap_reg + AW'(1);
                    if (rd_ptr_reg == '0)
                    begin
                        rd_ptr_reg <= LAST_TAP;
                    end
                    else
                    begin
                        rd_ptr_reg <= rd_ptr_reg - AW'(1);
                    end
                end
                S_SCALE:
                begin
                    if (stage_reg == STAGE_FIRST)
                    begin
                        stage_reg <= STAGE_SECOND;
                    end
                    else
                    begin
                        // Advance the shared write slot once both lines hold the sample
                        if (wptr_reg == LAST_TAP)
                        begin
                            wptr_reg <= '0;
                        end
                        else
                        begin
                            wptr_reg <= wptr_reg + AW'(1);
                        end
                        if (fill_reg != FULL)
                        begin
                            fill_reg <= fill_reg + CW'(1);
                        end
                    end
                end
                S_DRAIN, S_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Capture each stage's saturated result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCALE)
        begin
            if (stage_reg == STAGE_FIRST)
            begin
                y1_reg <= sat_value;
            end
            else
            begin
                y2_reg <= sat_value;
            end
        end
    end

    assign stage      = stage_reg;
    assign line_waddr = wptr_reg;
    assign line_raddr = rd_ptr_reg;
    assign coef_raddr = tap_reg;
    assign y1         = y1_reg;
    assign y2         = y2_reg;

endmodule

`default_nettype wire

// ===== design/cascaded_fir_notch_filter.sv =====
// ---------------------------------------------------------------------------
// cascaded_fir_notch_filter
// Two cascaded Q15 FIR filters on 16-bit audio, one shared MAC unit.
// ---------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_valid / in_stall. A coefficient write
//   (operation = 1) is stored at once and leaves in_stall low; an index at
//   or beyond TAPS is dropped. A filter request (operation = 0) runs the
//   sample through stage one, feeds the saturated result into stage two and
//   returns one sample on out_valid / out_stall.
//   A filter request runs each stage through a load state, a MAC state that
//   feeds every tap into the single multiply-accumulate unit, a drain state
//   that waits for the unit to empty and a scale state. in_stall stays
//   high meanwhile, so no new request is taken during a filter request.
//   The next request is taken as soon as the result sits in the output
//   register, even while the receiver stalls it; a second result waits
//   until the first has been taken.
//   output_select is written on cfg_valid / cfg_ready (always ready): 0
//   returns stage one, 1 returns stage two.
//   Reset clears the delay lines (through a fill count), output_select and
//   all handshake state; coefficients must be written before use.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cascaded_fir_notch_filter
    import cfn_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Input request channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         operation,
    input  wire logic signed [SAMPLE_W-1:0]   sample_in,
    input  wire logic                         coef_filter,
    input  wire logic [COEF_IDX_W-1:0]        coef_index,
    input  wire logic signed [SAMPLE_W-1:0]   coef_value,
    // Result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [SAMPLE_W-1:0]        sample_out,
    // Configuration write channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         output_select
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(TAPS + 1);

    logic                       accept;
    logic                       busy;
    logic                       start;
    logic                       coef_we;
    logic [IDX_EXT_W-1:0]       coef_idx_ext;
    logic [AW-1:0]              coef_waddr;
    logic                       out_free;
    logic                       load_out;
    logic                       sel_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    mac_ctrl_t                  mac_ctrl;
    mac_stat_t                  mac_stat;
    stage_t                     stage;
    logic                       line_we;
    logic [AW-1:0]              line_waddr;
    logic [AW-1:0]              line_raddr;
    logic [AW-1:0]              coef_raddr;
    logic signed [SAMPLE_W-1:0] line_wdata;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
    logic signed [SAMPLE_W-1:0] sat_value;
    logic [SAMPLE_W-1:0]        line_a_rdata;
    logic [SAMPLE_W-1:0]        line_b_rdata;
    logic [SAMPLE_W-1:0]        coef_a_rdata;
    logic [SAMPLE_W-1:0]        coef_b_rdata;
    logic signed [SAMPLE_W-1:0] mac_coef;
    logic signed [SAMPLE_W-1:0] mac_data;

    // Request decode
    assign in_stall     = busy;
    assign accept       = in_valid && !in_stall;
    assign start        = accept && (operation == OP_FILTER);
    assign coef_idx_ext = IDX_EXT_W'(coef_index);
    assign coef_we      = accept && (operation == OP_COEF) &&
                          (coef_idx_ext < IDX_EXT_W'(TAPS));
    assign coef_waddr   = coef_idx_ext[AW-1:0];

    // Hold the sample of a filter request
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg <= sample_in;
        end
    end

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sel_reg <= output_select;
        end
    end

    // Delay lines share write slot and read pointer
    assign line_wdata = (stage == STAGE_SECOND) ? y1 : sample_reg;

    cfn_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_line_a (
        .clk   (clk),
        .we    (line_we && (stage == STAGE_FIRST)),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_a_rdata)
    );

    cfn_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_line_b (
        .clk   (clk),
        .we    (line_we && (stage == STAGE_SECOND)),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_b_rdata)
    );

    // Coefficient tables
    cfn_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_coef_a (
        .clk   (clk),
        .we    (coef_we && (coef_filter == STAGE_FIRST)),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (coef_raddr),
        .rdata (coef_a_rdata)
    );

    cfn_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_coef_b (
        .clk   (clk),
        .we    (coef_we && (coef_filter == STAGE_SECOND)),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (coef_raddr),
        .rdata (coef_b_rdata)
    );

    // Feed the active stage into the MAC
    assign mac_coef = (stage == STAGE_SECOND) ? coef_b_rdata : coef_a_rdata;
    assign mac_data = (stage == STAGE_SECOND) ? line_b_rdata : line_a_rdata;

    cfn_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (mac_coef),
        .data   (mac_data),
        .stat   (mac_stat),
        .result (sat_value)
    );

    cfn_seq #(
        .TAPS (TAPS),
        .AW   (AW),
        .CW   (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .out_free   (out_free),
        .mac_stat   (mac_stat),
        .sat_value  (sat_value),
        .mac_ctrl   (mac_ctrl),
        .busy       (busy),
        .stage      (stage),
        .line_we    (line_we),
        .line_waddr (line_waddr),
        .line_raddr (line_raddr),
        .coef_raddr (coef_raddr),
        .y1         (y1),
        .y2         (y2),
        .load_out   (load_out)
    );

    // Output register: load when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sample_out_reg <= sel_reg ? y2 : y1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

`default_nettype wire

// ===== design/cfn_checker.sv =====
// ---------------------------------------------------------------------------
// cfn_port_checks
// Port-level checks of the cascaded FIR notch filter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cfn_port_checks
    import cfn_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       operation,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic signed [SAMPLE_W-1:0] sample_out
);

    // A stalled result stays and holds its value
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out))

    // A filter request keeps the block busy afterwards
    `ASSERT_NEXT(a_filter_busy, in_valid && !in_stall && (operation == OP_FILTER), in_stall)

    // A coefficient write costs no busy time
    `ASSERT_NEXT(a_coef_free, in_valid && !in_stall && (operation == OP_COEF), !in_stall)

    // A new result only follows a cycle of filter work
    `ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))

endmodule

bind cascaded_fir_notch_filter cfn_port_checks u_cfn_port_checks (.*);

`default_nettype wire

// ===== test/cfn_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfn_checker
// Watches the request, result and select channels of the cascaded FIR
// filter. It keeps its own delay lines, coefficient tables and output
// select, predicts the sample for every filter request that is accepted,
// and compares each accepted result with the oldest predicted sample.
// ---------------------------------------------------------------------------

module cfn_checker
    import cfn_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic                       operation,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic                       coef_filter,
    input  wire logic [COEF_IDX_W-1:0]      coef_index,
    input  wire logic signed [SAMPLE_W-1:0] coef_value,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_out,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic                       output_select,
    output int                              fail_count,
    output int                              pending
);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam logic signed [63:0] Q_MAX = 64'sd32767;
    localparam logic signed [63:0] Q_MIN = -64'sd32768;

    sample_t tap_line [2][TAPS];
    sample_t tap_coef [2][TAPS];
    logic    cascade_sel;
    sample_t predicted_samples [$];
    int      report_count;

    // Drop the fraction (floor) and clamp to the 16-bit range
    function automatic sample_t scale_saturate(logic signed [63:0] acc);
        logic signed [63:0] q;
        q = acc >>> FRAC_BITS;
        if (q > Q_MAX)
            q = Q_MAX;
        if (q < Q_MIN)
            q = Q_MIN;
        return q[SAMPLE_W-1:0];
    endfunction

    // Shift one sample into a stage's delay line and form its output
    function automatic sample_t run_fir(stage_t st, sample_t x);
        logic signed [63:0]       acc;
        logic signed [PROD_W-1:0] prod;
        acc = '0;
        for (int i = TAPS - 1; i > 0; i--)
            tap_line[st][i] = tap_line[st][i - 1];
        tap_line[st][0] = x;
        for (int i = 0; i < TAPS; i++)
        begin
            prod = tap_coef[st][i] * tap_line[st][i];
            acc  = acc + prod;
        end
        return scale_saturate(acc);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_t got_sample;
        sample_t want_sample;
        sample_t stage1_y;
        sample_t stage2_y;
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                tap_line[0][i] = '0;
                tap_line[1][i] = '0;
            end
            cascade_sel = 1'b0;
            predicted_samples.delete();
            fail_count   = 0;
            report_count = 0;
            pending <= 0;
        end
        else
        begin
            // Compare an accepted result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got_sample = sample_out;
                if (predicted_samples.size() == 0)
                begin
                    fail_count++;
                    if (report_count < 10)
                        $display("checker: result %0d at %0t with no request outstanding",
                                 got_sample, $time);
                    report_count++;
                end
                else
                begin
                    want_sample = predicted_samples.pop_front();
                    if (got_sample !== want_sample)
                    begin
                        fail_count++;
                        if (report_count < 10)
                            $display("checker: sample_out at %0t expected %0d, got %0d",
                                     $time, want_sample, got_sample);
                        report_count++;
                    end
                end
            end

            // Store a coefficient or predict a filter request
            if (in_valid && !in_stall)
            begin
                if (operation == OP_COEF)
                begin
                    if (int'(coef_index) < TAPS)
                        tap_coef[coef_filter][coef_index] = coef_value;
                end
                else
                begin
                    stage1_y = run_fir(STAGE_FIRST, sample_in);
                    stage2_y = run_fir(STAGE_SECOND, stage1_y);
                    predicted_samples.push_back(cascade_sel ? stage2_y : stage1_y);
                end
            end

            // Track the output select register
            if (cfg_valid && cfg_ready)
                cascade_sel = output_select;

            pending <= predicted_samples.size();
        end
    end

endmodule

// ===== test/tb_cascaded_fir_notch_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cascaded_fir_notch_filter
// Drives coefficient loads, filter requests and output select writes into
// the cascaded FIR filter with random gaps and stalls on both channels,
// including a long receiver hold-off, and reports the checker's verdict.
// ---------------------------------------------------------------------------

module tb_cascaded_fir_notch_filter;
    import cfn_pkg::*;

    localparam int TAPS          = 64;
    localparam int SETTLE_CYCLES = 2 * TAPS + 60;
    localparam int LONG_HOLD     = 1200;
    localparam int PHASE_ITEMS   = 110;
    localparam int PHASES        = 6;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum int {
        PROF_MAX,
        PROF_MIN,
        PROF_FULL,
        PROF_SMALL,
        PROF_SPARSE
    } coef_profile_t;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       in_valid      = 1'b0;
    logic                       operation     = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_in     = '0;
    logic                       coef_filter   = 1'b0;
    logic [COEF_IDX_W-1:0]      coef_index    = '0;
    logic signed [SAMPLE_W-1:0] coef_value    = '0;
    logic                       out_stall     = 1'b0;
    logic                       cfg_valid     = 1'b0;
    logic                       output_select = 1'b0;
    wire logic                  in_stall;
    wire logic                  out_valid;
    wire logic                  cfg_ready;
    wire logic signed [SAMPLE_W-1:0] sample_out;

    logic quiet   = 1'b0;
    logic hold_go = 1'b0;
    int   checker_fails;
    int   results_pending;

    always #4 clk = ~clk;

    cascaded_fir_notch_filter #(
        .TAPS(TAPS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .sample_in    (sample_in),
        .coef_filter  (coef_filter),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .output_select(output_select)
    );

    cfn_checker #(
        .TAPS(TAPS)
    ) fir_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .sample_in    (sample_in),
        .coef_filter  (coef_filter),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .output_select(output_select),
        .fail_count   (checker_fails),
        .pending      (results_pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(40, 100);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return ($urandom_range(0, 1) != 0) ? SAT_MAX : SAT_MIN;
        if (r < 50)
            return sample_t'($urandom_range(0, 16'hFFFF));
        return sample_t'(int'($urandom_range(0, 511)) - 256);
    endfunction

    function automatic sample_t pick_coef(coef_profile_t prof);
        case (prof)
            PROF_MAX:    return SAT_MAX;
            PROF_MIN:    return SAT_MIN;
            PROF_SMALL:  return sample_t'(int'($urandom_range(0, 2047)) - 1024);
            PROF_SPARSE: return ($urandom_range(0, 7) == 0) ?
                                sample_t'($urandom_range(0, 16'hFFFF)) : sample_t'(0);
            default:     return sample_t'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_req(op_t op, sample_t x, stage_t st,
                            logic [COEF_IDX_W-1:0] idx, sample_t cv);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        sample_in   <= x;
        coef_filter <= st;
        coef_index  <= idx;
        coef_value  <= cv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_sample(sample_t x);
        send_req(OP_FILTER, x, stage_t'($urandom_range(0, 1)),
                 COEF_IDX_W'($urandom_range(0, 63)), sample_t'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic send_coef(stage_t st, logic [COEF_IDX_W-1:0] idx, sample_t cv);
        send_req(OP_COEF, sample_t'($urandom_range(0, 16'hFFFF)), st, idx, cv);
    endtask

    task automatic load_table(stage_t st, coef_profile_t prof);
        for (int i = 0; i < TAPS; i++)
            send_coef(st, COEF_IDX_W'(i), pick_coef(prof));
    endtask

    // Stop sending, let every result drain, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_select(logic sel);
        cfg_valid     <= 1'b1;
        output_select <= sel;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, one long counted hold-off on request
    initial
    begin : receiver
        int span;
        bit held;
        held = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_go && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                span = quiet ? 0 : pick_gap();
                out_stall <= (span > 0);
                repeat ((span > 0) ? span : 1) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        sample_t       corner_samples [8];
        logic          phase_sel      [PHASES];
        bit            phase_reload   [PHASES];
        coef_profile_t phase_prof     [PHASES];
        coef_profile_t prof;
        corner_samples = '{SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, 16'sd0, -16'sd1, 16'sd1, SAT_MAX};
        phase_sel      = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        phase_reload   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_prof     = '{PROF_SMALL, PROF_SMALL, PROF_SPARSE, PROF_SPARSE,
                           PROF_FULL, PROF_SMALL};

        // Hold reset, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme coefficient tables, stage one output
        write_select(1'b0);
        load_table(STAGE_FIRST, PROF_MAX);
        load_table(STAGE_SECOND, PROF_MIN);
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);

        // Coefficient writes between samples leave the delay lines alone
        send_coef(STAGE_FIRST, COEF_IDX_W'(0), SAT_MIN);
        send_coef(STAGE_FIRST, COEF_IDX_W'(TAPS - 1), 16'sd0);
        send_coef(STAGE_SECOND, COEF_IDX_W'(0), SAT_MAX);
        send_coef(STAGE_SECOND, COEF_IDX_W'(TAPS - 1), 16'sd1);
        send_sample(SAT_MIN);
        send_sample(-16'sd1);

        // Same corners through the cascade
        wait_idle();
        write_select(1'b1);
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);

        // Random phases over both select settings and several tables
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_select(phase_sel[ph]);
            prof = phase_prof[ph];
            quiet <= (ph == 1 || ph == 3);
            if (ph == 3)
                hold_go <= 1'b1;
            if (phase_reload[ph])
            begin
                load_table(STAGE_FIRST, prof);
                load_table(STAGE_SECOND, prof);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 25)
                    send_coef(stage_t'($urandom_range(0, 1)),
                              COEF_IDX_W'($urandom_range(0, TAPS - 1)),
                              ($urandom_range(0, 9) == 0) ? pick_coef(PROF_FULL)
                                                          : pick_coef(prof));
                else
                    send_sample(pick_sample());
            end
        end

        // Drain and give the verdict
        wait_idle();
        if (checker_fails == 0 && results_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/cfn_pkg.sv
design/cfn_ram.sv
design/cfn_mac.sv
design/cfn_seq.sv
design/cascaded_fir_notch_filter.sv
design/cfn_checker.sv
test/cfn_checker.sv
test/tb_cascaded_fir_notch_filter.sv
